FILE: hdl/spq_pkg.sv
// Package with types, codes and defaults for the sorted priority queue.
`default_nettype none

package spq_pkg;

    localparam int DEPTH_DEF      = 16;
    localparam int TID_WIDTH_DEF  = 8;
    localparam int PRIO_WIDTH_DEF = 8;

    localparam int TID_FIELD_W    = 8;
    localparam int PRIO_FIELD_W   = 8;

    localparam logic CMD_INSERT = 1'b0;
    localparam logic CMD_REMOVE = 1'b1;

    localparam logic [1:0] STATUS_INSERTED = 2'd0;
    localparam logic [1:0] STATUS_REMOVED  = 2'd1;
    localparam logic [1:0] STATUS_EMPTY    = 2'd2;
    localparam logic [1:0] STATUS_FULL     = 2'd3;

    typedef struct packed {
        logic                    command;
        logic [TID_FIELD_W-1:0]  entry_tid;
        logic [PRIO_FIELD_W-1:0] entry_priority;
    } spq_in_t;

    typedef struct packed {
        logic [TID_FIELD_W-1:0]  out_tid;
        logic [PRIO_FIELD_W-1:0] out_priority;
        logic [1:0]              status;
    } spq_out_t;

    // Operation broadcast to every cell, already qualified by the handshake.
    typedef struct packed {
        logic ins;
        logic rem;
    } spq_op_t;

endpackage

`default_nettype wire

FILE: hdl/sorted_priority_queue.sv
// Top level of the stable sorted priority queue built as a chain of cells.
//
//   Channel   Direction   Handshake              Payload
//   in        input       in_valid / in_ready    in_data  (spq_in_t)
//   out       output      out_valid / out_ready  out_data (spq_out_t)
//
// All cells compare against the new entry in parallel and shift one place left or
// right, so one command is taken per cycle while in_ready is high. Its result sits
// in an output register and appears the cycle after.
// in_ready is low only while that register holds a result that is not taken.
// Reset empties the queue at once; no clearing pass is needed.
`default_nettype none

module sorted_priority_queue
    import spq_pkg::*;
#(
    parameter int DEPTH      = DEPTH_DEF,
    parameter int TID_WIDTH  = TID_WIDTH_DEF,
    parameter int PRIO_WIDTH = PRIO_WIDTH_DEF
) (
    input  wire logic     clk,
    input  wire logic     rst_n,
    input  wire logic     in_valid,
    output logic          in_ready,
    input  wire spq_in_t  in_data,
    output logic          out_valid,
    input  wire logic     out_ready,
    output spq_out_t      out_data
);

    logic                  valid_w [DEPTH];
    logic                  keep_w  [DEPTH];
    logic [TID_WIDTH-1:0]  tid_w   [DEPTH];
    logic [PRIO_WIDTH-1:0] prio_w  [DEPTH];

    logic                  accept;
    logic                  full;
    logic                  empty;
    logic [TID_WIDTH-1:0]  new_tid;
    logic [PRIO_WIDTH-1:0] new_prio;
    spq_op_t               op;

    logic                  out_valid_reg, out_valid_next;
    spq_out_t              out_reg, out_next;

    assign in_ready = !out_valid_reg || out_ready;
    assign accept   = in_valid && in_ready;

    assign full     = valid_w[DEPTH-1];
    assign empty    = !valid_w[0];
    assign new_tid  = TID_WIDTH'(in_data.entry_tid);
    assign new_prio = PRIO_WIDTH'(in_data.entry_priority);

    assign op.ins = accept && (in_data.command == CMD_INSERT) && !full;
    assign op.rem = accept && (in_data.command == CMD_REMOVE) && !empty;

    for (genvar i = 0; i < DEPTH; i++)
    begin : g_cell
        logic                  l_valid, l_keep, r_valid;
        logic [TID_WIDTH-1:0]  l_tid, r_tid;
        logic [PRIO_WIDTH-1:0] l_prio, r_prio;

        if (i == 0)
        begin : g_head
            // The head has nothing to its left, so a displaced head takes the new entry.
            assign l_valid = 1'b1;
            assign l_keep  = 1'b1;
            assign l_tid   = new_tid;
            assign l_prio  = new_prio;
        end
        else
        begin : g_body
            assign l_valid = valid_w[i-1];
            assign l_keep  = keep_w[i-1];
            assign l_tid   = tid_w[i-1];
            assign l_prio  = prio_w[i-1];
        end

        if (i == DEPTH - 1)
        begin : g_tail
            assign r_valid = 1'b0;
            assign r_tid   = tid_w[i];
            assign r_prio  = prio_w[i];
        end
        else
        begin : g_inner
            assign r_valid = valid_w[i+1];
            assign r_tid   = tid_w[i+1];
            assign r_prio  = prio_w[i+1];
        end

        spq_cell #(
            .TID_WIDTH  (TID_WIDTH),
            .PRIO_WIDTH (PRIO_WIDTH)
        ) u_cell (
            .clk         (clk),
            .rst_n       (rst_n),
            .op          (op),
            .new_tid     (new_tid),
            .new_prio    (new_prio),
            .left_valid  (l_valid),
            .left_keep   (l_keep),
            .left_tid    (l_tid),
            .left_prio   (l_prio),
            .right_valid (r_valid),
            .right_tid   (r_tid),
            .right_prio  (r_prio),
            .valid       (valid_w[i]),
            .keep        (keep_w[i]),
            .tid         (tid_w[i]),
            .prio        (prio_w[i])
        );
    end

    always_comb
    begin
        out_valid_next = out_valid_reg;
        out_next       = out_reg;
        if (out_ready)
        begin
            out_valid_next = 1'b0;
        end
        if (accept)
        begin
            out_valid_next        = 1'b1;
            out_next.out_tid      = '0;
            out_next.out_priority = '0;
            if (in_data.command == CMD_INSERT)
            begin
                out_next.status = full ? STATUS_FULL : STATUS_INSERTED;
            end
            else if (empty)
            begin
                out_next.status = STATUS_EMPTY;
            end
            else
            begin
                out_next.status       = STATUS_REMOVED;
                out_next.out_tid      = TID_FIELD_W'(tid_w[0]);
                out_next.out_priority = PRIO_FIELD_W'(prio_w[0]);
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        out_reg <= out_next;
    end

    assign out_valid = out_valid_reg;
    assign out_data  = out_reg;

endmodule

`default_nettype wire

FILE: hdl/spq_cell.sv
// One slot of the sorted chain: holds an entry and trades it with its neighbors.
`default_nettype none

module spq_cell
    import spq_pkg::*;
#(
    parameter int TID_WIDTH  = TID_WIDTH_DEF,
    parameter int PRIO_WIDTH = PRIO_WIDTH_DEF
) (
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    input  wire spq_op_t               op,
    input  wire logic [TID_WIDTH-1:0]  new_tid,
    input  wire logic [PRIO_WIDTH-1:0] new_prio,
    input  wire logic                  left_valid,
    input  wire logic                  left_keep,
    input  wire logic [TID_WIDTH-1:0]  left_tid,
    input  wire logic [PRIO_WIDTH-1:0] left_prio,
    input  wire logic                  right_valid,
    input  wire logic [TID_WIDTH-1:0]  right_tid,
    input  wire logic [PRIO_WIDTH-1:0] right_prio,
    output logic                       valid,
    output logic                       keep,
    output logic [TID_WIDTH-1:0]       tid,
    output logic [PRIO_WIDTH-1:0]      prio
);

    logic                  valid_reg, valid_next;
    logic [TID_WIDTH-1:0]  tid_reg, tid_next;
    logic [PRIO_WIDTH-1:0] prio_reg, prio_next;

    // An entry stays put when it sorts no later than the new one, which keeps
    // equal priorities in arrival order.
    assign keep = valid_reg && (prio_reg <= new_prio);

    always_comb
    begin
        valid_next = valid_reg;
        tid_next   = tid_reg;
        prio_next  = prio_reg;
        if (op.ins)
        begin
            if (!keep)
            begin
                if (left_keep)
                begin
                    valid_next = 1'b1;
                    tid_next   = new_tid;
                    prio_next  = new_prio;
                end
                else
                begin
                    valid_next = left_valid;
                    tid_next   = left_tid;
                    prio_next  = left_prio;
                end
            end
        end
        else if (op.rem)
        begin
            valid_next = right_valid;
            tid_next   = right_tid;
            prio_next  = right_prio;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        tid_reg  <= tid_next;
        prio_reg <= prio_next;
    end

    assign valid = valid_reg;
    assign tid   = tid_reg;
    assign prio  = prio_reg;

endmodule

`default_nettype wire

FILE: bench/testbench.sv
// Self-checking testbench for the stable sorted priority queue.
`default_nettype none

module testbench;
    import spq_pkg::*;

    localparam int QDEPTH        = DEPTH_DEF;
    localparam int STALL_LIMIT   = 2000;
    localparam int PRESSURE_HOLD = 300;

    logic     clk       = 1'b0;
    logic     rst_n     = 1'b0;
    logic     in_valid  = 1'b0;
    logic     in_ready;
    spq_in_t  in_data   = '0;
    logic     out_valid;
    logic     out_ready = 1'b0;
    spq_out_t out_data;

    sorted_priority_queue i_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .in_data   (in_data),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .out_data  (out_data)
    );

    // Shadow copy of the queue contents, head at index 0.
    logic [TID_FIELD_W-1:0]  shadow_tid  [QDEPTH];
    logic [PRIO_FIELD_W-1:0] shadow_prio [QDEPTH];
    int                      shadow_count = 0;

    spq_out_t awaited_results [$];

    int send_idle_pct = 0;
    int recv_idle_pct = 0;
    int hold_left     = 0;
    int errors        = 0;
    int stall_cycles  = 0;

    always
    begin
        #1 clk = 1'b1;
        #1 clk = 1'b0;
    end

    // Updates the shadow queue for one accepted command and returns its result.
    function automatic spq_out_t apply_command(spq_in_t item);
        spq_out_t res;
        int       pos;
        res = '0;
        if (item.command == CMD_INSERT)
        begin
            if (shadow_count >= QDEPTH)
            begin
                res.status = STATUS_FULL;
            end
            else
            begin
                // Equal priorities go behind the ones already stored.
                pos = 0;
                while (pos < shadow_count && shadow_prio[pos] <= item.entry_priority)
                    pos++;
                for (int i = shadow_count; i > pos; i--)
                begin
                    shadow_tid[i]  = shadow_tid[i-1];
                    shadow_prio[i] = shadow_prio[i-1];
                end
                shadow_tid[pos]  = item.entry_tid;
                shadow_prio[pos] = item.entry_priority;
                shadow_count++;
                res.status = STATUS_INSERTED;
            end
        end
        else if (shadow_count == 0)
        begin
            res.status = STATUS_EMPTY;
        end
        else
        begin
            res.out_tid      = shadow_tid[0];
            res.out_priority = shadow_prio[0];
            for (int i = 0; i + 1 < shadow_count; i++)
            begin
                shadow_tid[i]  = shadow_tid[i+1];
                shadow_prio[i] = shadow_prio[i+1];
            end
            shadow_count--;
            res.status = STATUS_REMOVED;
        end
        return res;
    endfunction

    // Mostly clustered values so that ties are common.
    function automatic logic [PRIO_FIELD_W-1:0] random_priority();
        case ($urandom_range(2))
            0: return PRIO_FIELD_W'($urandom_range(255));
            1: return PRIO_FIELD_W'($urandom_range(3));
            default: return PRIO_FIELD_W'($urandom_range(255, 252));
        endcase
    endfunction

    function automatic logic [TID_FIELD_W-1:0] random_tid();
        return TID_FIELD_W'($urandom_range(255));
    endfunction

    task automatic send_item(input logic cmd, input logic [TID_FIELD_W-1:0] tid,
                             input logic [PRIO_FIELD_W-1:0] prio);
        spq_in_t item;
        item.command        = cmd;
        item.entry_tid      = tid;
        item.entry_priority = prio;
        while ($urandom_range(99) < send_idle_pct)
        begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid <= 1'b1;
        in_data  <= item;
        @(posedge clk);
        while (!in_ready)
            @(posedge clk);
        awaited_results.push_back(apply_command(item));
    endtask

    task automatic test_directed_edges();
        send_item(CMD_REMOVE, 8'hFF, 8'hFF);
        send_item(CMD_INSERT, 8'h00, 8'h00);
        send_item(CMD_INSERT, 8'hFF, 8'hFF);
        send_item(CMD_INSERT, 8'hAA, 8'h80);
        send_item(CMD_INSERT, 8'h55, 8'h80);
        send_item(CMD_INSERT, 8'h01, 8'h7F);
        send_item(CMD_INSERT, 8'hFE, 8'h00);
        repeat (6)
            send_item(CMD_REMOVE, 8'h5A, 8'hA5);
        send_item(CMD_REMOVE, 8'h00, 8'h00);
    endtask

    // The receiver first stalls, which holds off the inserts; then the queue is filled past its depth and drained.
    task automatic test_full_under_backpressure();
        hold_left = PRESSURE_HOLD;
        for (int n = 0; n < QDEPTH + 2; n++)
            send_item(CMD_INSERT, random_tid(), random_priority());
        for (int n = 0; n <= QDEPTH; n++)
            send_item(CMD_REMOVE, random_tid(), PRIO_FIELD_W'($urandom_range(255)));
    endtask

    // Insert-heavy, then remove-heavy, then balanced traffic.
    task automatic test_random_traffic(input int sender_idle, input int receiver_idle);
        int insert_pct;
        send_idle_pct = sender_idle;
        recv_idle_pct = receiver_idle;
        for (int n = 0; n < 165; n++)
        begin
            insert_pct = (n < 60) ? 80 : (n < 110) ? 25 : 55;
            send_item(($urandom_range(99) < insert_pct) ? CMD_INSERT : CMD_REMOVE,
                      random_tid(), random_priority());
        end
    endtask

    initial
    begin
        repeat (3)
            @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_directed_edges();
        test_full_under_backpressure();
        test_random_traffic(18, 76);
        test_random_traffic(76, 18);
        test_random_traffic(0, 0);
        in_valid <= 1'b0;
        while (awaited_results.size() != 0)
            @(posedge clk);
        repeat (10)
            @(posedge clk);
        if (errors == 0)
            $display("** sorted_priority_queue: PASSED **");
        else
            $display("** sorted_priority_queue: FAILED **");
        $finish;
    end

    // Result checker and receiver-side flow control.
    initial
    begin
        spq_out_t want;
        forever
        begin
            @(posedge clk);
            if (rst_n && out_valid && out_ready)
            begin
                if (awaited_results.size() == 0)
                begin
                    errors++;
                    if (errors <= 10)
                        $display("unexpected transaction: tid %0h prio %0h status %0d",
                                 out_data.out_tid, out_data.out_priority, out_data.status);
                end
                else
                begin
                    want = awaited_results.pop_front();
                    if (want.out_tid !== out_data.out_tid
                        || want.out_priority !== out_data.out_priority
                        || want.status !== out_data.status)
                    begin
                        errors++;
                        if (errors <= 10)
                            $display("mismatch: expected tid %0h prio %0h status %0d,",
                                     want.out_tid, want.out_priority, want.status,
                                     " got tid %0h prio %0h status %0d",
                                     out_data.out_tid, out_data.out_priority,
                                     out_data.status);
                    end
                end
            end
            if (hold_left > 0)
            begin
                hold_left--;
                out_ready <= 1'b0;
            end
            else
            begin
                out_ready <= ($urandom_range(99) >= recv_idle_pct);
            end
        end
    end

    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if ((in_valid && in_ready) || (out_valid && out_ready))
            begin
                stall_cycles = 0;
            end
            else
            begin
                stall_cycles++;
                if (stall_cycles >= STALL_LIMIT)
                begin
                    $display("** sorted_priority_queue: FAILED **");
                    $finish;
                end
            end
        end
    end

endmodule

`default_nettype wire
